// ===== sv/pfpr_pkg.sv =====
// Shared types and constants for the parameter frame parser and responder.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package pfpr_pkg;

   // Frame bytes and codes.
   localparam logic [7:0] HDR_BYTE  = 8'hAA;
   localparam logic [7:0] FN_CMD    = 8'hE0;
   localparam logic [7:0] FN_PARAM  = 8'hE1;
   localparam logic [7:0] LEN_READ  = 8'h0B;
   localparam logic [7:0] LEN_WRITE = 8'h06;

   // Configuration register reset values and indexes.
   localparam logic [7:0] OWN_ADDR_RESET = 8'h05;
   localparam logic [7:0] GND_ADDR_RESET = 8'hAF;
   localparam logic       CSR_OWN_ADDR   = 1'b0;
   localparam logic       CSR_GND_ADDR   = 1'b1;

   // Number of frame bytes that a response can ever echo.
   localparam int FRAME_KEEP     = 17;
   localparam int ECHO_READ_LEN  = 17;
   localparam int ECHO_WRITE_LEN = 12;

   localparam int TABLE_DEPTH_DEFAULT = 64;
   localparam int QUEUE_DEPTH         = 2;

   // One decoded frame, handed from the parser to the responder.
   typedef struct packed {
      logic                       is_read;
      logic [15:0]                slot;
      logic [31:0]                wval;
      logic [FRAME_KEEP-1:0][7:0] echo;
   } job_type;

endpackage

`default_nettype wire

// ===== sv/pfpr_front.sv =====
// Frame parser: hunts for frames, keeps their bytes, checks the checksum and
// emits a decoded job. Depends on pfpr_pkg.
`default_nettype none

module pfpr_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [7:0]       own_addr,
   input  wire logic [7:0]       gnd_addr,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [7:0]       req_tdata,
   input  wire logic             q_full,
   input  wire logic             clearing,
   output logic                  push,
   output pfpr_pkg::job_type     job
);
   import pfpr_pkg::*;

   localparam logic [2:0] PH_HUNT  = 3'd0;
   localparam logic [2:0] PH_GND   = 3'd1;
   localparam logic [2:0] PH_OWN   = 3'd2;
   localparam logic [2:0] PH_FUNC  = 3'd3;
   localparam logic [2:0] PH_LEN   = 3'd4;
   localparam logic [2:0] PH_DATA  = 3'd5;
   localparam logic [2:0] PH_CHECK = 3'd6;

   localparam int IW        = $clog2(FRAME_KEEP);
   localparam int DATA_BASE = 5;
   localparam int KEEP_DATA = FRAME_KEEP - DATA_BASE;

   logic [2:0]    phase_ff, phase_in;
   logic [7:0]    bytes_left_ff, bytes_left_in;
   logic [7:0]    data_count_ff, data_count_in;
   logic          is_write_ff, is_write_in;
   logic [7:0]    sum_ff, sum_in;
   logic [7:0]    frame_ff [1:FRAME_KEEP-1];

   logic          accept;
   logic [7:0]    b;
   logic          wr_en;
   logic [IW-1:0] wr_idx;
   logic          sum_ok, read_ok, write_ok;
   logic [IW-1:0] end_idx;

   assign b          = req_tdata;
   assign req_tready = !clearing && !(phase_ff == PH_CHECK && q_full);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      data_count_in = data_count_ff;
      is_write_in   = is_write_ff;
      sum_in        = sum_ff;
      wr_en         = 1'b0;
      wr_idx        = '0;
      if (accept) begin
         case (phase_ff)
            PH_HUNT: begin
               if (b == HDR_BYTE) begin
                  phase_in = PH_GND;
                  sum_in   = b;
               end
            end
            PH_GND: begin
               if (b == gnd_addr) begin
                  phase_in = PH_OWN;
                  wr_en    = 1'b1;
                  wr_idx   = IW'(1);
                  sum_in   = sum_ff + b;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_OWN: begin
               if (b == own_addr) begin
                  phase_in = PH_FUNC;
                  wr_en    = 1'b1;
                  wr_idx   = IW'(2);
                  sum_in   = sum_ff + b;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_FUNC: begin
               if (b == FN_CMD || b == FN_PARAM) begin
                  phase_in    = PH_LEN;
                  is_write_in = (b == FN_PARAM);
                  wr_en       = 1'b1;
                  wr_idx      = IW'(3);
                  sum_in      = sum_ff + b;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_LEN: begin
               phase_in      = PH_DATA;
               wr_en         = 1'b1;
               wr_idx        = IW'(4);
               sum_in        = sum_ff + b;
               bytes_left_in = b;
               data_count_in = '0;
            end
            PH_DATA: begin
               if (bytes_left_ff == 8'd0) begin
                  phase_in = PH_HUNT;
               end else begin
                  // Data bytes past the last echoed position are summed only.
                  wr_en         = (data_count_ff < 8'(KEEP_DATA));
                  wr_idx        = IW'(DATA_BASE) + data_count_ff[IW-1:0];
                  sum_in        = sum_ff + b;
                  data_count_in = data_count_ff + 8'd1;
                  bytes_left_in = bytes_left_ff - 8'd1;
                  if (bytes_left_ff == 8'd1) begin
                     phase_in = PH_CHECK;
                  end
               end
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   // Frame decode on the checksum byte.
   assign sum_ok   = (b == sum_ff);
   assign read_ok  = !is_write_ff && frame_ff[4] == LEN_READ && frame_ff[5] == FN_PARAM;
   assign write_ok = is_write_ff && frame_ff[4] == LEN_WRITE;
   assign push     = accept && phase_ff == PH_CHECK && sum_ok && (read_ok || write_ok);
   assign end_idx  = is_write_ff ? IW'(ECHO_WRITE_LEN - 1) : IW'(ECHO_READ_LEN - 1);

   always_comb begin
      job.is_read = !is_write_ff;
      job.slot    = is_write_ff ? {frame_ff[5], frame_ff[6]} : {frame_ff[6], frame_ff[7]};
      job.wval    = {frame_ff[7], frame_ff[8], frame_ff[9], frame_ff[10]};
      job.echo[0] = HDR_BYTE;
      job.echo[1] = frame_ff[2];
      job.echo[2] = frame_ff[1];
      for (int k = 3; k < FRAME_KEEP; k++) begin
         job.echo[k] = (IW'(k) == end_idx) ? b : frame_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         bytes_left_ff <= '0;
         data_count_ff <= '0;
         is_write_ff   <= 1'b0;
         sum_ff        <= '0;
      end else begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         data_count_ff <= data_count_in;
         is_write_ff   <= is_write_in;
         sum_ff        <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k < FRAME_KEEP; k++) begin
         if (wr_en && wr_idx == IW'(k)) begin
            frame_ff[k] <= b;
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/pfpr_queue.sv =====
// Short job queue between the frame parser and the responder.
// Depends on pfpr_pkg for the job type and depth.
`default_nettype none

module pfpr_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire pfpr_pkg::job_type job_in,
   output logic                   full,
   input  wire logic              pop,
   output logic                   valid,
   output pfpr_pkg::job_type      job_out
);
   import pfpr_pkg::*;

   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   job_type       entry_ff [QUEUE_DEPTH];
   logic [QW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QW:0]   count_ff, count_in;

   assign full    = (count_ff == (QW+1)'(QUEUE_DEPTH));
   assign valid   = (count_ff != '0);
   assign job_out = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (QW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/pfpr_back.sv =====
// Responder: owns the parameter table, runs each job and streams the echo and
// reply bytes through an output register. Depends on pfpr_pkg.
`default_nettype none

module pfpr_back #(
   parameter int TABLE_DEPTH = pfpr_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [7:0]        own_addr,
   input  wire logic [7:0]        gnd_addr,
   input  wire logic              q_valid,
   input  wire pfpr_pkg::job_type q_job,
   output logic                   pop,
   output logic                   clearing,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tlast
);
   import pfpr_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   localparam logic [3:0] POS_HDR    = 4'd0;
   localparam logic [3:0] POS_SRC    = 4'd1;
   localparam logic [3:0] POS_DST    = 4'd2;
   localparam logic [3:0] POS_FUNC   = 4'd3;
   localparam logic [3:0] POS_LEN    = 4'd4;
   localparam logic [3:0] POS_SLOT_H = 4'd5;
   localparam logic [3:0] POS_SLOT_L = 4'd6;
   localparam logic [3:0] POS_VAL_3  = 4'd7;
   localparam logic [3:0] POS_VAL_2  = 4'd8;
   localparam logic [3:0] POS_VAL_1  = 4'd9;
   localparam logic [3:0] POS_VAL_0  = 4'd10;
   localparam logic [3:0] POS_SUM    = 4'd11;

   logic [31:0]                table_mem [TABLE_DEPTH];
   logic [31:0]                rd_data_ff;
   logic                       clr_ff;
   logic [AW-1:0]              clr_addr_ff;

   logic                       busy_ff;
   logic [4:0]                 cnt_ff;
   logic                       is_read_ff;
   logic                       in_range_ff;
   logic [15:0]                slot_ff;
   logic [31:0]                wval_ff;
   logic [FRAME_KEEP-1:0][7:0] echo_ff;
   logic [7:0]                 sum_ff;

   logic                       out_valid_ff;
   logic [7:0]                 out_data_ff;
   logic                       out_last_ff;

   logic                       start, adv, slot_in_range, in_echo, is_last;
   logic [AW-1:0]              job_addr;
   logic [4:0]                 echo_len, rdiff;
   logic [3:0]                 rpos;
   logic [31:0]                value;
   logic [7:0]                 rep_byte, byte_sel;

   assign clearing      = clr_ff;
   assign start         = !busy_ff && !clr_ff && q_valid;
   assign pop           = start;
   assign slot_in_range = (q_job.slot < 16'(TABLE_DEPTH));
   assign job_addr      = q_job.slot[AW-1:0];

   assign adv      = busy_ff && (!out_valid_ff || rsp_tready);
   assign echo_len = is_read_ff ? 5'(ECHO_READ_LEN) : 5'(ECHO_WRITE_LEN);
   assign in_echo  = (cnt_ff < echo_len);
   assign rdiff    = cnt_ff - echo_len;
   assign rpos     = rdiff[3:0];
   assign value    = in_range_ff ? (is_read_ff ? rd_data_ff : wval_ff) : 32'd0;
   assign is_last  = !in_echo && rpos == POS_SUM;
   assign byte_sel = in_echo ? echo_ff[0] : rep_byte;

   always_comb begin
      case (rpos)
         POS_HDR:    rep_byte = HDR_BYTE;
         POS_SRC:    rep_byte = own_addr;
         POS_DST:    rep_byte = gnd_addr;
         POS_FUNC:   rep_byte = FN_PARAM;
         POS_LEN:    rep_byte = LEN_WRITE;
         POS_SLOT_H: rep_byte = slot_ff[15:8];
         POS_SLOT_L: rep_byte = slot_ff[7:0];
         POS_VAL_3:  rep_byte = value[31:24];
         POS_VAL_2:  rep_byte = value[23:16];
         POS_VAL_1:  rep_byte = value[15:8];
         POS_VAL_0:  rep_byte = value[7:0];
         default:    rep_byte = sum_ff;
      endcase
   end

   // Parameter table: one write port shared by the clearing pass and writes,
   // one registered read port used when a job starts.
   always_ff @(posedge clock) begin
      if (clr_ff) begin
         table_mem[clr_addr_ff] <= '0;
      end else if (start && !q_job.is_read && slot_in_range) begin
         table_mem[job_addr] <= q_job.wval;
      end
      if (start) begin
         rd_data_ff <= table_mem[job_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_ff) begin
         if (clr_addr_ff == AW'(TABLE_DEPTH - 1)) begin
            clr_ff <= 1'b0;
         end else begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (adv) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (is_last) begin
               busy_ff <= 1'b0;
            end
         end
         if (adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         is_read_ff  <= q_job.is_read;
         in_range_ff <= slot_in_range;
         slot_ff     <= q_job.slot;
         wval_ff     <= q_job.wval;
         echo_ff     <= q_job.echo;
         sum_ff      <= '0;
      end else if (adv) begin
         if (in_echo) begin
            echo_ff <= {8'h00, echo_ff[FRAME_KEEP-1:1]};
         end else if (!is_last) begin
            sum_ff <= sum_ff + rep_byte;
         end
      end
      if (adv) begin
         out_data_ff <= byte_sel;
         out_last_ff <= is_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

// ===== sv/param_frame_parser_responder_unit.sv =====
// Parameter frame parser and responder, top level. Depends on pfpr_pkg,
// pfpr_front, pfpr_queue and pfpr_back.
// Throughput: one request byte per cycle while req_tready is high, one response
// byte per cycle while rsp_tready allows; a burst is 29 bytes for a read, 24 for
// a write, with the output idle between bursts. With the responder idle, the
// first response byte passes the queue, the job registers and the output
// register after the checksum byte is accepted. Reset is synchronous; after it,
// the parameter table is cleared one entry per cycle, with req_tready held low.
`default_nettype none

module param_frame_parser_responder_unit #(
   parameter int TABLE_DEPTH = pfpr_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // Request stream of received link bytes.
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,    // [7:0] rx_byte
   // Response stream.
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,    // [7:0] tx_byte
   output logic            rsp_tlast,    // tx_last
   // Configuration writes.
   input  wire logic       csr_wen,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_wdata
);
   import pfpr_pkg::*;

   // Two address registers, read by the parser (address matching) and responder
   // (reply header); the user must change them only while idle, not enforced here.
   logic [7:0] own_addr_ff, own_addr_in;
   logic [7:0] gnd_addr_ff, gnd_addr_in;

   always_comb begin
      own_addr_in = own_addr_ff;
      gnd_addr_in = gnd_addr_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_OWN_ADDR: own_addr_in = csr_wdata;
            CSR_GND_ADDR: gnd_addr_in = csr_wdata;
            default: begin
               own_addr_in = own_addr_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_addr_ff <= OWN_ADDR_RESET;
         gnd_addr_ff <= GND_ADDR_RESET;
      end else begin
         own_addr_ff <= own_addr_in;
         gnd_addr_ff <= gnd_addr_in;
      end
   end

   // The parser turns a checksum-valid read or write frame into one job; the
   // queue lets it keep taking request bytes while a burst is still going out.
   logic    push, q_full, q_valid, pop, clearing;
   job_type front_job, queue_job;

   pfpr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .own_addr   (own_addr_ff),
      .gnd_addr   (gnd_addr_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .clearing   (clearing),
      .push       (push),
      .job        (front_job)
   );

   pfpr_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .job_in  (front_job),
      .full    (q_full),
      .pop     (pop),
      .valid   (q_valid),
      .job_out (queue_job)
   );

   // The responder applies writes to the table, reads back the slot value and
   // streams the echoed frame followed by the reply frame.
   pfpr_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .own_addr   (own_addr_ff),
      .gnd_addr   (gnd_addr_ff),
      .q_valid    (q_valid),
      .q_job      (queue_job),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== dv/tb_param_frame_parser_responder_unit.sv =====
// Self-checking testbench for param_frame_parser_responder_unit: directed frames
// and random link traffic, checked byte by byte against a behavioral predictor.
// Depends on pfpr_pkg and the unit itself; nothing else is read or needed.
`default_nettype none

module tb_param_frame_parser_responder_unit;
   import pfpr_pkg::*;

   // Parameter table depth of the instance; slots at or above it read as zero.
   localparam int TBL_DEPTH    = TABLE_DEPTH_DEFAULT;
   // A reply frame is always twelve bytes; the echo in front of it depends on
   // the kind of request frame.
   localparam int REPLY_LEN    = 12;
   localparam int READ_BURST   = ECHO_READ_LEN + REPLY_LEN;
   localparam int WRITE_BURST  = ECHO_WRITE_LEN + REPLY_LEN;
   // Bounds on waiting. The drain bound covers two queued bursts under the
   // heaviest receiver stall many times over; the run limit covers the slowest
   // correct run, clearing pass included, with a wide margin.
   localparam int DRAIN_LIMIT  = 5000;
   localparam int TAIL_CYCLES  = 8;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int RANDOM_QUOTA = 12;
   localparam int PRINT_CAP    = 40;

   typedef logic [7:0] byte_q_t[$];

   // One expected response byte.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } tx_beat_t;

   // Parser phases of the predictor, in the order a frame walks through them.
   typedef enum logic [2:0] {
      PH_HUNT, PH_GND, PH_OWN, PH_FUNC, PH_LEN, PH_DATA, PH_SUM
   } parse_ph_t;

   // Kinds of directed stimulus rows.
   typedef enum logic [3:0] {
      ROW_READ, ROW_WRITE, ROW_BADSUM, ROW_ZEROLEN, ROW_SHORTREAD,
      ROW_LONGWRITE, ROW_NOTPARAM, ROW_REHDR, ROW_WRONGFN
   } row_kind_t;

   // A directed row. Where known is set, the row also carries the burst length
   // and reply value that can be read straight off the protocol; a length of
   // zero means that no burst may come back at all.
   typedef struct packed {
      row_kind_t   kind;
      logic [15:0] slot;
      logic [31:0] wval;
      logic        known;
      logic [4:0]  want_len;
      logic [31:0] want_val;
   } dir_row_t;

   // DUT signals. Every input starts at a known value.
   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_tvalid  = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata   = 8'h00;
   logic       rsp_tvalid;
   logic       rsp_tready  = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       csr_wen     = 1'b0;
   logic       csr_index   = CSR_OWN_ADDR;
   logic [7:0] csr_wdata   = 8'h00;

   // Predictor state: parser, frame bytes seen, parameter table, addresses.
   parse_ph_t   rx_ph;
   logic [7:0]  left_cnt;
   logic [7:0]  got_cnt;
   logic [7:0]  sum_acc;
   logic        is_wr;
   logic [7:0]  seen_bytes [FRAME_KEEP];
   logic [31:0] slot_mem   [TBL_DEPTH];
   logic [7:0]  own_now;
   logic [7:0]  gnd_now;

   // Response bytes that the predictor expects, oldest first.
   tx_beat_t tx_expect_q[$];
   tx_beat_t due_beat;

   // Pacing of both sides, in percent of cycles spent idle.
   int unsigned snd_idle_pct = 0;
   int unsigned rcv_idle_pct = 0;

   // Bookkeeping of what came back, used by the directed checks and summary.
   logic [39:0] tail_bytes   = '0;
   logic [31:0] last_val     = '0;
   int          burst_len    = 0;
   int          last_len     = 0;
   int          burst_total  = 0;
   int          rsp_total    = 0;
   int          rx_total     = 0;
   int          answered     = 0;
   int          stored       = 0;
   int          settings     = 1;
   int          err_count    = 0;

   dir_row_t dir_tab [16];

   param_frame_parser_responder_unit #(.TABLE_DEPTH(TBL_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] rx_byte
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [7:0] tx_byte
      .rsp_tlast  (rsp_tlast),    // tx_last
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Clock with a period of four time units.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Hard stop in case the unit hangs or drops a request.
   initial begin
      #(CYCLE_LIMIT * 4);
      $display("FAILURE");
      $finish;
   end

   // Every mismatch goes through here: one line, and the count goes up. The
   // printing is capped so that a badly broken unit cannot flood the log.
   task automatic flag_mismatch(input string msg);
      if (err_count < PRINT_CAP)
         $display("MISMATCH: %s", msg);
      err_count++;
   endtask

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   function automatic void reset_model();
      rx_ph    = PH_HUNT;
      left_cnt = '0;
      got_cnt  = '0;
      sum_acc  = '0;
      is_wr    = 1'b0;
      own_now  = OWN_ADDR_RESET;
      gnd_now  = GND_ADDR_RESET;
      foreach (seen_bytes[i])
         seen_bytes[i] = '0;
      foreach (slot_mem[i])
         slot_mem[i] = '0;
   endfunction

   // Frame bytes past the end of the store are parsed but not kept.
   function automatic void keep_seen(input int idx, input logic [7:0] b);
      if (idx < FRAME_KEEP)
         seen_bytes[idx] = b;
   endfunction

   function automatic void push_beat(input logic [7:0] b, input logic l);
      tx_expect_q.push_back(tx_beat_t'{data: b, last: l});
   endfunction

   // Expected burst for an accepted frame: the frame echoed with its address
   // bytes swapped, then a reply frame with the slot's value and its own sum.
   function automatic void queue_reply(input int flen, input logic [15:0] slot);
      logic [7:0]  rep [11];
      logic [7:0]  rsum;
      logic [31:0] val;
      val  = (slot < TBL_DEPTH) ? slot_mem[slot] : 32'h0;
      rsum = '0;
      push_beat(HDR_BYTE, 1'b0);
      push_beat(seen_bytes[2], 1'b0);
      push_beat(seen_bytes[1], 1'b0);
      for (int i = 3; i < flen && i < FRAME_KEEP; i++)
         push_beat(seen_bytes[i], 1'b0);
      rep = '{HDR_BYTE, own_now, gnd_now, FN_PARAM, LEN_WRITE, slot[15:8], slot[7:0],
              val[31:24], val[23:16], val[15:8], val[7:0]};
      foreach (rep[i]) begin
         rsum = rsum + rep[i];
         push_beat(rep[i], 1'b0);
      end
      push_beat(rsum, 1'b1);
      answered++;
   endfunction

   // Decision on a complete frame, taken on its checksum byte.
   function automatic void decode_frame(input logic [7:0] chk);
      int          flen;
      logic [15:0] slot;
      flen = int'(got_cnt) + 6;
      if (chk != sum_acc)
         return;
      if (!is_wr) begin
         if (seen_bytes[4] != LEN_READ || seen_bytes[5] != FN_PARAM)
            return;
         slot = {seen_bytes[6], seen_bytes[7]};
      end else begin
         if (seen_bytes[4] != LEN_WRITE)
            return;
         slot = {seen_bytes[5], seen_bytes[6]};
         if (slot < TBL_DEPTH) begin
            slot_mem[slot] = {seen_bytes[7], seen_bytes[8], seen_bytes[9], seen_bytes[10]};
            stored++;
         end
      end
      queue_reply(flen, slot);
   endfunction

   // Advances the predicted parser by one accepted request byte.
   function automatic void track_rx_byte(input logic [7:0] b);
      case (rx_ph)
         PH_HUNT: begin
            if (b == HDR_BYTE) begin
               rx_ph         = PH_GND;
               seen_bytes[0] = b;
               sum_acc       = b;
            end
         end
         PH_GND: begin
            if (b == gnd_now) begin
               rx_ph         = PH_OWN;
               seen_bytes[1] = b;
               sum_acc       = sum_acc + b;
            end else begin
               rx_ph = PH_HUNT;
            end
         end
         PH_OWN: begin
            if (b == own_now) begin
               rx_ph         = PH_FUNC;
               seen_bytes[2] = b;
               sum_acc       = sum_acc + b;
            end else begin
               rx_ph = PH_HUNT;
            end
         end
         PH_FUNC: begin
            if (b == FN_CMD || b == FN_PARAM) begin
               rx_ph         = PH_LEN;
               is_wr         = (b == FN_PARAM);
               seen_bytes[3] = b;
               sum_acc       = sum_acc + b;
            end else begin
               rx_ph = PH_HUNT;
            end
         end
         PH_LEN: begin
            rx_ph         = PH_DATA;
            seen_bytes[4] = b;
            sum_acc       = sum_acc + b;
            left_cnt      = b;
            got_cnt       = '0;
         end
         PH_DATA: begin
            // A zero length swallows the next byte and goes back to hunting.
            if (left_cnt == 0) begin
               rx_ph = PH_HUNT;
            end else begin
               keep_seen(int'(got_cnt) + 5, b);
               sum_acc  = sum_acc + b;
               got_cnt  = got_cnt + 8'd1;
               left_cnt = left_cnt - 8'd1;
               if (left_cnt == 0)
                  rx_ph = PH_SUM;
            end
         end
         PH_SUM: begin
            rx_ph = PH_HUNT;
            keep_seen(int'(got_cnt) + 5, b);
            decode_frame(b);
         end
         default: rx_ph = PH_HUNT;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Frame construction
   // ------------------------------------------------------------------

   // A frame to the current addresses with a correct checksum, or with the
   // checksum pushed off by a nonzero amount when spoil is set.
   function automatic byte_q_t build_frame(input logic [7:0] fn, input logic [7:0] len,
                                           input byte_q_t body, input bit spoil);
      byte_q_t    fq;
      logic [7:0] s;
      fq = '{HDR_BYTE, gnd_now, own_now, fn, len};
      foreach (body[i])
         fq.push_back(body[i]);
      s = '0;
      foreach (fq[i])
         s = s + fq[i];
      if (spoil)
         s = s + 8'd1 + 8'($urandom_range(0, 254));
      fq.push_back(s);
      return fq;
   endfunction

   // Read command body: parameter code, slot, then eight padding bytes.
   function automatic byte_q_t read_body(input logic [15:0] slot, input bit rand_pad);
      byte_q_t body;
      body = '{FN_PARAM, slot[15:8], slot[7:0]};
      repeat (8)
         body.push_back(rand_pad ? 8'($urandom) : 8'h00);
      return body;
   endfunction

   // Write body: slot, then the value most significant byte first.
   function automatic byte_q_t write_body(input logic [15:0] slot, input logic [31:0] val);
      byte_q_t body;
      body = '{slot[15:8], slot[7:0], val[31:24], val[23:16], val[15:8], val[7:0]};
      return body;
   endfunction

   // Mostly a handful of low slots so that reads find earlier writes, now and
   // then anywhere in the table, and sometimes beyond it.
   function automatic logic [15:0] pick_slot();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 16'($urandom_range(0, 7));
      else if (r < 85)
         return 16'($urandom_range(0, TBL_DEPTH - 1));
      return 16'($urandom_range(TBL_DEPTH, 65535));
   endfunction

   function automatic logic [31:0] pick_value();
      logic [31:0] edges [4];
      edges = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
      if ($urandom_range(0, 9) == 0)
         return edges[$urandom_range(0, 3)];
      return $urandom;
   endfunction

   // ------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------

   // Offers one request byte, with random idle cycles in front of it, and
   // returns at the rising edge where it was taken. Inputs only change at the
   // falling edge; req_tvalid stays high until the next decision.
   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = b;
      do
         @(posedge clock);
      while (!req_tready);
      track_rx_byte(b);
      rx_total++;
   endtask

   task automatic send_frame(input byte_q_t fq);
      foreach (fq[i])
         send_byte(fq[i]);
   endtask

   // Holds the sender off until every expected response byte has come back or
   // DRAIN_LIMIT runs out, then lets the unit run on for work that yields nothing.
   task automatic drain_responses();
      int waited = 0;
      @(negedge clock);
      req_tvalid = 1'b0;
      while (tx_expect_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (tx_expect_q.size() != 0) begin
         flag_mismatch($sformatf("%0d expected response bytes never arrived",
                                 tx_expect_q.size()));
         tx_expect_q.delete();
      end
      repeat (TAIL_CYCLES)
         @(negedge clock);
   endtask

   // New address settings. The parser is first walked back to hunting with
   // filler bytes, so that no frame straddles the change, and the unit is
   // drained; both registers are then written on consecutive cycles.
   task automatic retune(input logic [7:0] own_val, input logic [7:0] gnd_val);
      while (rx_ph != PH_HUNT)
         send_byte(8'h00);
      drain_responses();
      csr_wen   = 1'b1;
      csr_index = CSR_OWN_ADDR;
      csr_wdata = own_val;
      @(posedge clock);
      own_now = own_val;
      @(negedge clock);
      csr_index = CSR_GND_ADDR;
      csr_wdata = gnd_val;
      @(posedge clock);
      gnd_now = gnd_val;
      @(negedge clock);
      csr_wen = 1'b0;
      settings++;
   endtask

   // Random traffic: mostly well-formed reads and writes with random content,
   // the rest bad checksums, odd lengths, cut-off frames and plain noise.
   task automatic run_random(input int quota);
      int          start;
      int unsigned r;
      int unsigned n;
      logic [15:0] slot;
      logic [31:0] val;
      logic [7:0]  fn;
      logic [7:0]  len;
      byte_q_t     body;
      byte_q_t     fq;
      start = rx_total;
      while (rx_total - start < quota) begin
         r    = $urandom_range(0, 99);
         slot = pick_slot();
         val  = pick_value();
         fn   = r[0] ? FN_CMD : FN_PARAM;
         if (r < 40) begin
            fq = build_frame(FN_PARAM, LEN_WRITE, write_body(slot, val), 1'b0);
         end else if (r < 75) begin
            fq = build_frame(FN_CMD, LEN_READ, read_body(slot, 1'b1), 1'b0);
         end else if (r < 82) begin
            if (fn == FN_CMD)
               fq = build_frame(FN_CMD, LEN_READ, read_body(slot, 1'b1), 1'b1);
            else
               fq = build_frame(FN_PARAM, LEN_WRITE, write_body(slot, val), 1'b1);
         end else if (r < 87) begin
            // Arbitrary short length with a body to match and a good checksum.
            len = 8'($urandom_range(0, 20));
            body.delete();
            repeat (len)
               body.push_back(8'($urandom));
            fq = build_frame(fn, len, body, 1'b0);
         end else if (r < 93) begin
            // A good frame cut short and followed by a stray byte.
            if (fn == FN_CMD)
               fq = build_frame(FN_CMD, LEN_READ, read_body(slot, 1'b1), 1'b0);
            else
               fq = build_frame(FN_PARAM, LEN_WRITE, write_body(slot, val), 1'b0);
            n = $urandom_range(1, fq.size() - 1);
            while (fq.size() > n)
               void'(fq.pop_back());
            fq.push_back(8'($urandom));
         end else begin
            fq.delete();
            repeat ($urandom_range(1, 4))
               fq.push_back(($urandom_range(0, 3) == 0) ? HDR_BYTE : 8'($urandom));
         end
         send_frame(fq);
      end
   endtask

   // ------------------------------------------------------------------
   // Receiver and response checking
   // ------------------------------------------------------------------

   // The receiver stalls at random; its ready changes at the falling edge.
   always @(negedge clock)
      rsp_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);

   // Each accepted response byte is compared with the oldest expectation. The
   // last five bytes of each burst are kept so that the directed rows can look
   // at the reply value directly.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (tx_expect_q.size() == 0) begin
            flag_mismatch($sformatf("response byte %02h (last %0b) with nothing expected",
                                    rsp_tdata, rsp_tlast));
         end else begin
            due_beat = tx_expect_q.pop_front();
            if (rsp_tdata !== due_beat.data)
               flag_mismatch($sformatf("response byte %0d: data %02h, expected %02h",
                                       rsp_total, rsp_tdata, due_beat.data));
            if (rsp_tlast !== due_beat.last)
               flag_mismatch($sformatf("response byte %0d: last %0b, expected %0b",
                                       rsp_total, rsp_tlast, due_beat.last));
         end
         tail_bytes = {tail_bytes[31:0], rsp_tdata};
         burst_len++;
         rsp_total++;
         if (rsp_tlast) begin
            last_val = tail_bytes[39:8];
            last_len = burst_len;
            burst_len = 0;
            burst_total++;
         end
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------

   initial begin
      int          bursts_then;
      dir_row_t    row;
      byte_q_t     fq;
      byte_q_t     body;

      // Directed rows. The typed-in results follow from the reset state and
      // from values written just before; the rest rely on the predictor.
      dir_tab = '{
         '{ROW_READ,      16'd0,     32'h0,         1'b1, 5'(READ_BURST),  32'h0},
         '{ROW_WRITE,     16'd0,     32'h7FFF_FFFF, 1'b1, 5'(WRITE_BURST), 32'h7FFF_FFFF},
         '{ROW_WRITE,     16'd63,    32'h8000_0000, 1'b1, 5'(WRITE_BURST), 32'h8000_0000},
         '{ROW_READ,      16'd63,    32'h0,         1'b1, 5'(READ_BURST),  32'h8000_0000},
         '{ROW_WRITE,     16'd64,    32'h1234_5678, 1'b1, 5'(WRITE_BURST), 32'h0},
         '{ROW_READ,      16'hFFFF,  32'h0,         1'b1, 5'(READ_BURST),  32'h0},
         '{ROW_WRITE,     16'd1,     32'hFFFF_FFFF, 1'b1, 5'(WRITE_BURST), 32'hFFFF_FFFF},
         '{ROW_READ,      16'd0,     32'h0,         1'b1, 5'(READ_BURST),  32'h7FFF_FFFF},
         '{ROW_BADSUM,    16'd2,     32'h0000_0005, 1'b1, 5'd0,            32'h0},
         '{ROW_ZEROLEN,   16'd0,     32'h0,         1'b1, 5'd0,            32'h0},
         '{ROW_SHORTREAD, 16'd3,     32'h0000_0001, 1'b1, 5'd0,            32'h0},
         '{ROW_LONGWRITE, 16'd4,     32'hA5A5_5A5A, 1'b1, 5'd0,            32'h0},
         '{ROW_NOTPARAM,  16'd1,     32'h0,         1'b1, 5'd0,            32'h0},
         '{ROW_REHDR,     16'd0,     32'h0,         1'b1, 5'd0,            32'h0},
         '{ROW_WRONGFN,   16'd1,     32'h0,         1'b0, 5'd0,            32'h0},
         '{ROW_READ,      16'd1,     32'h0,         1'b1, 5'(READ_BURST),  32'hFFFF_FFFF}
      };

      reset_model();
      // Reset is held from the start and released at a falling edge. The
      // clearing pass that follows shows up only as req_tready held low.
      repeat (5)
         @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // First idling setting: sender idles lightly, receiver heavily.
      snd_idle_pct = 19;
      rcv_idle_pct = 69;

      // Directed part, at the reset addresses.
      foreach (dir_tab[k]) begin
         row = dir_tab[k];
         bursts_then = burst_total;
         case (row.kind)
            ROW_READ:
               fq = build_frame(FN_CMD, LEN_READ, read_body(row.slot, 1'b0), 1'b0);
            ROW_WRITE:
               fq = build_frame(FN_PARAM, LEN_WRITE, write_body(row.slot, row.wval), 1'b0);
            ROW_BADSUM:
               fq = build_frame(FN_PARAM, LEN_WRITE, write_body(row.slot, row.wval), 1'b1);
            ROW_ZEROLEN: begin
               // The checksum byte after the empty body is swallowed.
               body.delete();
               fq = build_frame(FN_PARAM, 8'd0, body, 1'b0);
            end
            ROW_SHORTREAD:
               // A command with the write length is parsed and dropped.
               fq = build_frame(FN_CMD, LEN_WRITE, write_body(row.slot, row.wval), 1'b0);
            ROW_LONGWRITE: begin
               // Too long for the store; the tail is summed but not kept.
               body = write_body(row.slot, row.wval);
               repeat (24)
                  body.push_back(8'($urandom));
               fq = build_frame(FN_PARAM, 8'd30, body, 1'b0);
            end
            ROW_NOTPARAM: begin
               body    = read_body(row.slot, 1'b0);
               body[0] = FN_CMD;
               fq = build_frame(FN_CMD, LEN_READ, body, 1'b0);
            end
            ROW_REHDR: begin
               // The second header breaks the first frame and is not itself
               // taken as a new start, so the whole read is lost.
               fq = build_frame(FN_CMD, LEN_READ, read_body(row.slot, 1'b0), 1'b0);
               fq.push_front(HDR_BYTE);
            end
            default:
               fq = build_frame(8'h55, LEN_READ, read_body(row.slot, 1'b0), 1'b0);
         endcase
         send_frame(fq);
         if (row.known) begin
            drain_responses();
            if (row.want_len == 0) begin
               if (burst_total != bursts_then)
                  flag_mismatch($sformatf("directed row %0d: a response came back", k));
            end else if (burst_total != bursts_then + 1 || last_len != int'(row.want_len) ||
                         last_val != row.want_val) begin
               flag_mismatch($sformatf("directed row %0d: %0d bursts, length %0d, value %08h",
                                       k, burst_total - bursts_then, last_len, last_val));
            end
         end
      end

      // Random part at the lowest own address and the highest ground address.
      retune(8'h00, 8'hFF);
      run_random(RANDOM_QUOTA);

      // The other way round, in addresses and in idling.
      snd_idle_pct = 69;
      rcv_idle_pct = 19;
      retune(8'hFF, 8'h00);
      run_random(RANDOM_QUOTA);

      // No idling at all, with random addresses; the retune between the two
      // halves also makes the sender wait until every response is out.
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      retune(8'($urandom), 8'($urandom));
      run_random(RANDOM_QUOTA);
      retune(8'($urandom), 8'($urandom));
      run_random(RANDOM_QUOTA);

      drain_responses();

      $display("Run covered %0d request bytes and %0d response bytes in %0d bursts.",
               rx_total, rsp_total, burst_total);
      $display("Frames answered: %0d, table writes: %0d, address settings: %0d.",
               answered, stored, settings);
      if (err_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
sv/pfpr_pkg.sv
sv/pfpr_front.sv
sv/pfpr_queue.sv
sv/pfpr_back.sv
sv/param_frame_parser_responder_unit.sv
dv/tb_param_frame_parser_responder_unit.sv
